/* src/psq_pkg.sv */
// Shared types and constants for the pulse-width square oscillator.
// No dependencies; imported by every module of the block.
package psq_pkg;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic REG_DUTY_TARGET = 1'b0;
    localparam logic REG_SMOOTH_COEF = 1'b1;

    localparam logic [15:0] DUTY_RESET = 16'd32768;
    localparam logic [15:0] COEF_RESET = 16'd65471;

    localparam logic [16:0] COEF_ONE    = 17'd65536;
    localparam logic [33:0] SMOOTH_RND  = 34'd32768;
    localparam logic [37:0] SCALE_RND   = 38'd163840;
    localparam logic [20:0] DIV_BIAS    = 21'd655360;
    localparam logic [16:0] DIV5_RECIP  = 17'd52429;
    localparam logic [21:0] OUT_BIAS    = 22'd131072;
    localparam logic signed [21:0] OUT_MAX = 22'sd131071;
    localparam logic signed [21:0] OUT_MIN = -22'sd131072;

    typedef struct packed {
        logic               func;
        logic               wr_ok;
        logic [10:0]        addr;
        logic signed [15:0] value;
        logic [26:0]        phase_inc;
        logic signed [15:0] pwm_mod;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic [15:0] duty_target;
        logic [15:0] smooth_coef;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM1,
        ST_SM2,
        ST_POS,
        ST_RD2A,
        ST_RD2B,
        ST_RD2C,
        ST_MUL,
        ST_SCL,
        ST_DIV,
        ST_FIX
    } state_t;

endpackage

/* src/psq_front.sv */
// Input side: accepts words, tags table writes that fall inside the table,
// and holds them in a two-entry queue. Depends on psq_pkg.
module psq_front
    import psq_pkg::*;
#(
    parameter int ADDR_W = 11
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic [10:0]        table_addr,
    input  logic signed [15:0] table_value,
    input  logic [26:0]        phase_inc,
    input  logic signed [15:0] pwm_mod,
    output head_t              head,
    input  logic               head_pop
);

    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;
    logic [ADDR_W+10:0] addr_ext;
    item_t       in_item;

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = head_pop && (cnt_reg != 2'd0);

    assign addr_ext = (ADDR_W + 11)'(table_addr);

    always_comb
    begin
        in_item.func      = func;
        in_item.wr_ok     = (addr_ext[ADDR_W+10:ADDR_W] == 11'd0);
        in_item.addr      = table_addr;
        in_item.value     = table_value;
        in_item.phase_inc = phase_inc;
        in_item.pwm_mod   = pwm_mod;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

/* src/psq_back.sv */
// Execution side: owns the saw table, the duty smoother and phase, and
// sequences reads, interpolation and output scaling. Depends on psq_pkg.
module psq_back
    import psq_pkg::*;
#(
    parameter int ADDR_W = 11,
    parameter int FRAC_W = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  head_t              head,
    output logic               head_pop,
    output logic               oq_push,
    output logic signed [17:0] oq_data,
    input  logic               oq_full
);

    localparam int PW    = ADDR_W + FRAC_W;
    localparam int DEPTH = 1 << ADDR_W;

    state_t state_reg, state_next;

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rdata_reg;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W+10:0] waddr_ext;
    logic               mem_we;
    logic               item_load;

    logic [PW-1:0]      phase_reg, phase_next;
    logic [15:0]        ds_reg, ds_next;
    logic [PW-1:0]      inc_reg;
    logic [PW+26:0]     inc_ext;
    logic signed [15:0] pwm_reg;

    logic [31:0]        p1_reg;
    logic [32:0]        p2;
    logic [33:0]        acc;

    logic signed [15:0] a_reg, b_reg;
    logic [PW-1:0]      pos2_reg, pos2_next;
    logic [16:0]        s_reg, s_next;
    logic signed [17:0] dm;
    logic [PW+15:0]     off_w;
    logic signed [18:0] dd, dm_inv, s_full;

    logic signed [15:0]       ia, ib;
    logic [FRAC_W-1:0]        ifr;
    logic signed [16:0]       idiff;
    logic signed [FRAC_W+17:0] iprod, ishift;
    logic signed [16:0]       ival;
    logic signed [16:0]       r1_reg, r2_reg;

    logic signed [17:0] diff;
    logic signed [35:0] prod_reg;
    logic signed [37:0] x, xq;
    logic [20:0]        u_reg;
    logic [37:0]        qm_reg;
    logic [19:0]        q0;
    logic [23:0]        q5;
    logic signed [23:0] rem;
    logic [20:0]        q1;
    logic signed [21:0] res;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && head.item.func == FUNC_SAMPLE)
                begin
                    state_next = ST_SM1;
                end
            end
            ST_SM1:  state_next = ST_SM2;
            ST_SM2:  state_next = ST_POS;
            ST_POS:  state_next = ST_RD2A;
            ST_RD2A: state_next = ST_RD2B;
            ST_RD2B: state_next = ST_RD2C;
            ST_RD2C: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SCL;
            ST_SCL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_FIX;
            ST_FIX:
            begin
                if (!oq_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        head_pop  = 1'b0;
        mem_we    = 1'b0;
        item_load = 1'b0;
        oq_push   = 1'b0;
        raddr     = phase_reg[PW-1:FRAC_W];
        case (state_reg)
            ST_IDLE:
            begin
                head_pop  = head.valid;
                mem_we    = head.valid && (head.item.func == FUNC_WRITE) && head.item.wr_ok;
                item_load = head.valid && (head.item.func == FUNC_SAMPLE);
            end
            ST_SM1:  raddr = phase_reg[PW-1:FRAC_W];
            ST_SM2:  raddr = phase_reg[PW-1:FRAC_W] + ADDR_W'(1);
            ST_RD2A: raddr = pos2_reg[PW-1:FRAC_W];
            ST_RD2B: raddr = pos2_reg[PW-1:FRAC_W] + ADDR_W'(1);
            ST_FIX:  oq_push = !oq_full;
            default: raddr = phase_reg[PW-1:FRAC_W];
        endcase
    end

    assign waddr_ext = (ADDR_W + 11)'(head.item.addr);
    assign waddr     = waddr_ext[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= head.item.value;
        end
        rdata_reg <= mem[raddr];
    end

    // duty smoother
    assign p2      = 33'(COEF_ONE - {1'b0, cfg.smooth_coef}) * {17'd0, cfg.duty_target};
    assign acc     = 34'(p1_reg) + 34'(p2) + SMOOTH_RND;
    assign ds_next = (state_reg == ST_SM2) ? acc[31:16] : ds_reg;

    // phase advance
    assign inc_ext    = (PW + 27)'(head.item.phase_inc);
    assign phase_next = oq_push ? phase_reg + inc_reg : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            ds_reg    <= DUTY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ds_reg    <= ds_next;
        end
    end

    // offset position and scale factor
    always_comb
    begin
        dm        = $signed({2'b00, ds_reg}) + $signed({{2{pwm_reg[15]}}, pwm_reg});
        off_w     = {dm[15:0], {PW{1'b0}}};
        pos2_next = phase_reg + off_w[PW+15:16];
        if (dm[17])
        begin
            dd = $signed({dm[17], dm});
        end
        else
        begin
            dd = $signed({3'b000, dm[15:0]});
        end
        dm_inv = 19'sd65536 - dd;
        s_full = (dm_inv > dd) ? dm_inv : dd;
        s_next = s_full[16:0];
    end

    // shared interpolator
    always_comb
    begin
        ia     = a_reg;
        ib     = (state_reg == ST_RD2C) ? rdata_reg : b_reg;
        ifr    = (state_reg == ST_RD2C) ? pos2_reg[FRAC_W-1:0] : phase_reg[FRAC_W-1:0];
        idiff  = $signed({ib[15], ib}) - $signed({ia[15], ia});
        iprod  = (FRAC_W + 18)'(idiff) * (FRAC_W + 18)'($signed({1'b0, ifr}));
        ishift = iprod >>> FRAC_W;
        ival   = $signed({ia[15], ia}) + $signed(ishift[16:0]);
    end

    // output scaling: floor((3*diff*s + 163840) / 327680)
    always_comb
    begin
        diff = $signed({r1_reg[16], r1_reg}) - $signed({r2_reg[16], r2_reg});
        x    = (38'(prod_reg) <<< 1) + 38'(prod_reg) + $signed(SCALE_RND);
        xq   = x >>> 16;
        q0   = qm_reg[37:18];
        q5   = 24'(q0) * 24'd5;
        rem  = $signed(24'(u_reg)) - $signed(q5);
        if (rem < 24'sd0)
        begin
            q1 = 21'(q0) - 21'd1;
        end
        else if (rem >= 24'sd5)
        begin
            q1 = 21'(q0) + 21'd1;
        end
        else
        begin
            q1 = 21'(q0);
        end
        res = $signed({1'b0, q1}) - $signed(OUT_BIAS);
        if (res > OUT_MAX)
        begin
            oq_data = 18'(OUT_MAX);
        end
        else if (res < OUT_MIN)
        begin
            oq_data = 18'(OUT_MIN);
        end
        else
        begin
            oq_data = res[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            inc_reg <= inc_ext[PW-1:0];
            pwm_reg <= head.item.pwm_mod;
        end
        case (state_reg)
            ST_SM1:  p1_reg <= 32'(ds_reg) * 32'(cfg.smooth_coef);
            ST_SM2:  a_reg <= rdata_reg;
            ST_POS:
            begin
                b_reg    <= rdata_reg;
                pos2_reg <= pos2_next;
                s_reg    <= s_next;
            end
            ST_RD2A: r1_reg <= ival;
            ST_RD2B: a_reg <= rdata_reg;
            ST_RD2C: r2_reg <= ival;
            ST_MUL:  prod_reg <= 36'(diff) * 36'($signed({1'b0, s_reg}));
            ST_SCL:  u_reg <= xq[20:0] + DIV_BIAS;
            ST_DIV:  qm_reg <= 38'(u_reg) * 38'(DIV5_RECIP);
            default: u_reg <= u_reg;
        endcase
    end

endmodule

/* src/psq_oq.sv */
// Result queue: two entries of output samples between the engine and the
// consumer. Depends on psq_pkg only through the shared house style.
module psq_oq
    import psq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  logic signed [17:0] wr_data,
    output logic               q_full,
    input  logic               pop,
    output logic               empty,
    output logic signed [17:0] sample
);

    logic signed [17:0] q_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_wr, do_pop;

    assign q_full = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign do_wr  = wr && !q_full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_wr) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign sample = q_reg[rd_ptr_reg];

endmodule

/* src/pwm_square_from_two_saw_reads.sv */
// Pulse-width square oscillator: top level with the two config registers,
// input queue, execution engine and result queue. Depends on psq_pkg.
//
// Every word pushed is either a table write (func 0) or a sample request
// (func 1). A table write is done once it reaches the head of the
// two-entry input queue; a sample request runs from queue head to result
// through the four sequenced reads on the table's single read port and
// the multiply chain for smoothing, interpolation and scaling. Only one
// sample is in flight; push is refused while the input queue is full and
// results wait in a two-entry output queue. TABLE_LEN must be a power of
// two. The table is not cleared at reset: read only entries that were
// written. Write config registers only while the block is idle.
module pwm_square_from_two_saw_reads
    import psq_pkg::*;
#(
    parameter int TABLE_LEN       = 2048,
    parameter int PHASE_FRAC_BITS = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic [10:0]        table_addr,
    input  logic signed [15:0] table_value,
    input  logic [26:0]        phase_inc,
    input  logic signed [15:0] pwm_mod,
    output logic               empty,
    input  logic               pop,
    output logic signed [17:0] sample
);

    localparam int ADDR_W = $clog2(TABLE_LEN);

    logic [15:0]        duty_target_reg, duty_target_next;
    logic [15:0]        smooth_coef_reg, smooth_coef_next;
    cfg_t               cfg;
    head_t              head;
    logic               head_pop;
    logic               oq_push;
    logic               oq_full;
    logic signed [17:0] oq_data;

    always_comb
    begin
        duty_target_next = duty_target_reg;
        smooth_coef_next = smooth_coef_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DUTY_TARGET: duty_target_next = cfg_data;
                REG_SMOOTH_COEF: smooth_coef_next = cfg_data;
                default:         duty_target_next = duty_target_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_target_reg <= DUTY_RESET;
            smooth_coef_reg <= COEF_RESET;
        end
        else
        begin
            duty_target_reg <= duty_target_next;
            smooth_coef_reg <= smooth_coef_next;
        end
    end

    assign cfg.duty_target = duty_target_reg;
    assign cfg.smooth_coef = smooth_coef_reg;

    psq_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .table_addr  (table_addr),
        .table_value (table_value),
        .phase_inc   (phase_inc),
        .pwm_mod     (pwm_mod),
        .head        (head),
        .head_pop    (head_pop)
    );

    psq_back #(
        .ADDR_W (ADDR_W),
        .FRAC_W (PHASE_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .head_pop (head_pop),
        .oq_push  (oq_push),
        .oq_data  (oq_data),
        .oq_full  (oq_full)
    );

    psq_oq u_oq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (oq_push),
        .wr_data (oq_data),
        .q_full  (oq_full),
        .pop     (pop),
        .empty   (empty),
        .sample  (sample)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> !oq_full)
        else $error("result written into a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head.valid)
        else $error("engine took a word from an empty input queue");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |=> !empty)
        else $error("pushed result not visible");
`endif

endmodule

/* verif/pwm_square_from_two_saw_reads_test.sv */
// Testbench for pwm_square_from_two_saw_reads: a directed table, then random words in
// several duty/smoothing settings, each sample checked against an in-bench predictor.
// Depends on psq_pkg and the block's RTL only.
module pwm_square_from_two_saw_reads_test;
    timeunit 1ns;
    timeprecision 1ps;
    import psq_pkg::*;

    localparam int TBL_LEN     = 2048;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SEG_WORDS   = 320;
    localparam int SHOW_MAX    = 10;
    localparam int SETTLE      = 24;

    typedef struct {
        logic               fn;
        logic [10:0]        addr;
        logic signed [15:0] value;
        logic [26:0]        inc;
        logic signed [15:0] pm;
    } osc_word_t;

    typedef struct {
        osc_word_t          w;
        bit                 known;
        logic signed [17:0] want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_DUTY_TARGET;
    logic [15:0]        cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic               func = FUNC_WRITE;
    logic [10:0]        table_addr = '0;
    logic signed [15:0] table_value = '0;
    logic [26:0]        phase_inc = '0;
    logic signed [15:0] pwm_mod = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [17:0] sample;

    // predictor state
    logic [26:0]        phase_now = '0;
    logic [15:0]        duty_now = DUTY_RESET;
    logic [15:0]        duty_goal = DUTY_RESET;
    logic [15:0]        coef_now = COEF_RESET;
    logic signed [15:0] saw_copy [0:TBL_LEN-1];

    logic signed [17:0] samples_due [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 words_sent = 0;
    int                 samples_checked = 0;
    int                 settings_used = 1;
    int                 idle_pct = 10;
    int                 rx_hold = 0;

    dir_row_t dir_rows [0:21];

    pwm_square_from_two_saw_reads uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .func        (func),
        .table_addr  (table_addr),
        .table_value (table_value),
        .phase_inc   (phase_inc),
        .pwm_mod     (pwm_mod),
        .empty       (empty),
        .pop         (pop),
        .sample      (sample)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples outstanding",
                     cycles, samples_due.size());
            $display("pwm_square_from_two_saw_reads: mismatch");
            $finish;
        end
    end

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // linear interpolation between two neighboring entries, wrapping at the end
    function automatic longint saw_at(logic [26:0] pos);
        logic [10:0] idx;
        logic [10:0] nxt;
        longint      lo;
        longint      hi;
        idx = pos[26:16];
        nxt = idx + 11'd1;
        lo = saw_copy[idx];
        hi = saw_copy[nxt];
        return lo + (((hi - lo) * longint'(pos[15:0])) >>> 16);
    endfunction

    function automatic logic signed [17:0] next_square(logic signed [15:0] pm,
                                                       logic [26:0] inc);
        longint      acc;
        longint      dm;
        longint      offs;
        longint      diff;
        longint      d;
        longint      s;
        longint      res;
        logic [26:0] far_pos;
        acc = longint'(duty_now) * longint'(coef_now)
            + (65536 - longint'(coef_now)) * longint'(duty_goal) + 32768;
        duty_now = acc[31:16];
        dm = longint'(duty_now) + longint'(pm);
        offs = dm * TBL_LEN;
        far_pos = phase_now + offs[26:0];
        diff = saw_at(phase_now) - saw_at(far_pos);
        d = dm % 65536;
        s = (65536 - d > d) ? 65536 - d : d;
        res = floor_quot(2 * diff * s * 6 + 655360, 1310720);
        if (res > 131071)
            res = 131071;
        else if (res < -131072)
            res = -131072;
        phase_now = phase_now + inc;
        return res[17:0];
    endfunction

    function automatic osc_word_t random_word();
        osc_word_t w;
        w.fn = ($urandom_range(99) < 70) ? FUNC_SAMPLE : FUNC_WRITE;
        w.addr = 11'($urandom_range(TBL_LEN - 1));
        w.value = 16'($urandom);
        if ($urandom_range(3) == 0)
            w.inc = 27'($urandom);
        else
            w.inc = 27'($urandom_range(1 << 20));
        case ($urandom_range(5))
            0: w.pm = '0;
            1: w.pm = 16'sh7FFF;
            2: w.pm = 16'sh8000;
            3: w.pm = 16'($signed(12'($urandom)));
            default: w.pm = 16'($urandom);
        endcase
        return w;
    endfunction

    // push one word; push stays high afterwards so back-to-back words need no toggle
    task automatic send_word(input osc_word_t w, input bit known = 1'b0,
                             input logic signed [17:0] want = '0);
        logic signed [17:0] predicted;
        push        <= 1'b1;
        func        <= w.fn;
        table_addr  <= w.addr;
        table_value <= w.value;
        phase_inc   <= w.inc;
        pwm_mod     <= w.pm;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
        if (w.fn == FUNC_WRITE)
            saw_copy[w.addr] = w.value;
        else
        begin
            predicted = next_square(w.pm, w.inc);
            samples_due.push_back(known ? want : predicted);
        end
    endtask

    task automatic maybe_gap();
        if ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // hold the input until every sample is back, then let queued table writes finish
    task automatic drain();
        push <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] goal, input logic [15:0] coef);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DUTY_TARGET;
        cfg_data  <= goal;
        @(posedge clk);
        cfg_index <= REG_SMOOTH_COEF;
        cfg_data  <= coef;
        @(posedge clk);
        cfg_we    <= 1'b0;
        duty_goal = goal;
        coef_now = coef;
        settings_used++;
    endtask

    always @(posedge clk)
    begin : result_side
        logic signed [17:0] want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (samples_due.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display("unexpected sample %0d with nothing pending", sample);
                end
                else
                begin
                    want = samples_due.pop_front();
                    samples_checked++;
                    if (sample !== want)
                    begin
                        errors++;
                        if (errors <= SHOW_MAX)
                            $display("sample %0d: expected %0d, got %0d",
                                     samples_checked, want, sample);
                    end
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial
    begin : stimulus
        osc_word_t   w;
        logic [15:0] goal;
        logic [15:0] coef;
        int          i;
        int          seg;
        int          n;

        // zero table: the first samples must come out as zero
        dir_rows = '{
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'd0,          16'sd0},     1'b1, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'h7FFFFFF,    16'sh7FFF},  1'b1, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'd0,          16'sh8000},  1'b1, 18'sd0},
            '{'{FUNC_WRITE,  11'd0,    16'sh7FFF,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_WRITE,  11'd2047, 16'sh8000,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_WRITE,  11'd1,    16'sh8000,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_WRITE,  11'd1024, 16'sh7FFF,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_WRITE,  11'd1023, 16'sh4000,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_WRITE,  11'd2046, 16'sh7FFF,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'd1,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'd65536,      16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'h7FFFFFF,    16'sh7FFF},  1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'h4000000,    16'sh8000},  1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'h0008000,    16'sh7FFF},  1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'h5555555,    16'sh8000},  1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'd0,          16'sd1},     1'b0, 18'sd0},
            '{'{FUNC_WRITE,  11'h555,  16'sh5555,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_WRITE,  11'h2AA,  16'shAAAA,  27'd0,          16'sd0},     1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'h2AAAAAA,    16'sh5555},  1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'h1555555,    16'shAAAA},  1'b0, 18'sd0},
            '{'{FUNC_SAMPLE, 11'd0,    16'sd0,     27'd0,          16'sd0},     1'b0, 18'sd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < TBL_LEN; i++)
        begin
            w = '{FUNC_WRITE, 11'(i), 16'sd0, 27'd0, 16'sd0};
            send_word(w);
            maybe_gap();
        end

        foreach (dir_rows[r])
        begin
            send_word(dir_rows[r].w, dir_rows[r].known, dir_rows[r].want);
            maybe_gap();
        end

        // refill the whole table with random content before the random part
        for (i = 0; i < TBL_LEN; i++)
        begin
            w = random_word();
            w.fn = FUNC_WRITE;
            w.addr = 11'(i);
            send_word(w);
            maybe_gap();
        end

        for (seg = 0; seg < 5; seg++)
        begin
            case (seg)
                0:
                begin
                    goal = 16'd0;
                    coef = 16'd0;
                end
                1:
                begin
                    goal = 16'hFFFF;
                    coef = 16'hFFFF;
                end
                2:
                begin
                    goal = 16'hFFFF;
                    coef = 16'd0;
                end
                3:
                begin
                    goal = 16'($urandom);
                    coef = 16'($urandom);
                end
                default:
                begin
                    goal = DUTY_RESET;
                    coef = COEF_RESET;
                end
            endcase
            drain();
            set_config(goal, coef);
            idle_pct = (seg == 1) ? 0 : 10;
            for (n = 0; n < SEG_WORDS; n++)
            begin
                if (seg == 0 && n == 40)
                    rx_hold = 400;
                if (seg == 4 && n == SEG_WORDS / 2)
                    drain();
                send_word(random_word());
                maybe_gap();
            end
        end

        drain();
        $display("%0d words pushed, %0d samples checked over %0d duty/smoothing settings",
                 words_sent, samples_checked, settings_used);
        $display("%0d errors in %0d cycles", errors, cycles);
        if (errors == 0)
            $display("pwm_square_from_two_saw_reads: match");
        else
            $display("pwm_square_from_two_saw_reads: mismatch");
        $finish;
    end

endmodule
